@@ rtl/wpfe_pkg.sv @@
// ----------------------------------------------------------------------------
// wpfe_pkg
// Shared widths, the sequencer state type and a small helper for the window
// peak feature extractor.
// ----------------------------------------------------------------------------
package wpfe_pkg;

  // Sample and baseline width (two's complement)
  localparam int unsigned SampleW      = 16;
  localparam int unsigned MaxWindowDef = 256;

  // Result field widths
  localparam int unsigned ProminenceW = 17;
  localparam int unsigned IndexW      = 8;
  localparam int unsigned LengthW     = 9;
  localparam int unsigned AreaW       = 25;
  localparam int unsigned EnergyW     = 39;
  localparam int unsigned DeviationW  = 18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } wpfe_state_e;

  // Magnitude of a signed sample; the most negative value maps to 2**(SampleW-1)
  function automatic logic [SampleW-1:0] abs_s(logic signed [SampleW-1:0] v);
    return v[SampleW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

@@ rtl/window_peak_feature_extractor.sv @@
// ----------------------------------------------------------------------------
// window_peak_feature_extractor
// Per-window peak, excursion, step, area, energy and RMS features over a
// stream of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one sample word with a
//   last-sample marker. A window closes on the marked word or on the
//   MAX_WINDOW-th word, whichever comes first.
//   Each sample word is accepted, then its running values are updated, then
//   its square is accumulated; in_ready_o is low during the update and the
//   accumulation.
//   On a closing word the block runs one shared subtractor: first a restoring
//   divide of the energy by the length, one quotient bit a cycle, then a
//   digit-by-digit square root. The result word is loaded into the output
//   register after the root; no new word is taken before that.
//   A result word waiting in the output register does not hold up the next
//   window; only the following window close waits until it is taken.
//   cfg_we_i / cfg_wdata_i write the baseline level; write it while idle.
//   Reset clears the window state, the baseline level and the output valid.
// ----------------------------------------------------------------------------
module window_peak_feature_extractor
  import wpfe_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MaxWindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SampleW-1:0]     sample_i,
  input  logic                          last_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SampleW-1:0]     peak_amplitude_o,
  output logic        [SampleW-1:0]     abs_peak_o,
  output logic        [ProminenceW-1:0] twice_prominence_o,
  output logic signed [SampleW-1:0]     positive_excursion_o,
  output logic signed [SampleW-1:0]     negative_excursion_o,
  output logic        [IndexW-1:0]      peak_index_o,
  output logic        [LengthW-1:0]     window_length_o,
  output logic        [SampleW-1:0]     max_abs_step_o,
  output logic        [AreaW-1:0]       twice_area_o,
  output logic        [SampleW-1:0]     rms_value_o,
  output logic        [EnergyW-1:0]     energy_o,
  output logic signed [DeviationW-1:0]  twice_baseline_deviation_o,
  input  logic                          cfg_we_i,
  input  logic signed [SampleW-1:0]     cfg_wdata_i
);

  localparam int unsigned SW     = SampleW;
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_WINDOW);
  localparam int unsigned ASUM_W = SW + IDX_W;
  localparam int unsigned SQ_W   = 2 * SW - 1 + IDX_W;
  localparam int unsigned Q_W    = 2 * SW - 1;
  localparam int unsigned ALU_W  = ((CNT_W + 1 > Q_W) ? CNT_W + 1 : Q_W) + 1;
  localparam int unsigned ITER_W = $clog2(SQ_W);
  localparam int unsigned DEV_W  = SW + 2;

  wpfe_state_e state_q, state_d;

  // Control
  logic upd_en, acc_en, div_en, sqrt_en, fin_go;
  logic out_valid_q, out_valid_d;
  logic closing_q, closing_d;
  logic [ITER_W-1:0] iter_q, iter_d;

  // Window state
  logic        [CNT_W-1:0]  count_q, count_d;
  logic signed [SW-1:0]     first_q, first_d;
  logic signed [SW-1:0]     prev_q, prev_d;
  logic        [SW-1:0]     best_abs_q, best_abs_d;
  logic signed [SW-1:0]     best_sgn_q, best_sgn_d;
  logic        [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic signed [SW-1:0]     max_q, max_d;
  logic signed [SW-1:0]     min_q, min_d;
  logic        [SW-1:0]     step_q, step_d;
  logic        [ASUM_W-1:0] abs_sum_q, abs_sum_d;
  logic        [SQ_W-1:0]   sq_sum_q, sq_sum_d;
  logic signed [SW-1:0]     base_q;

  // Datapath payload
  logic signed [SW-1:0]    x_q;
  logic                    last_q;
  logic        [2*SW-1:0]  sq_q, sq_d;
  logic signed [DEV_W-1:0] dev_q, dev_d;
  logic        [SW:0]      edge_q, edge_d;
  logic        [SQ_W-1:0]  dq_q, dq_d;
  logic        [CNT_W-1:0] rem_q, rem_d;
  logic        [Q_W-1:0]   xr_q, xr_d;
  logic        [Q_W-1:0]   r_q, r_d;
  logic        [Q_W-1:0]   bit_q, bit_d;

  // Output register
  logic signed [SW-1:0]          o_peak_q;
  logic        [SW-1:0]          o_abs_q;
  logic        [ProminenceW-1:0] o_prom_q;
  logic signed [SW-1:0]          o_max_q;
  logic signed [SW-1:0]          o_min_q;
  logic        [IndexW-1:0]      o_idx_q;
  logic        [LengthW-1:0]     o_len_q;
  logic        [SW-1:0]          o_step_q;
  logic        [AreaW-1:0]       o_area_q;
  logic        [SW-1:0]          o_rms_q;
  logic        [EnergyW-1:0]     o_energy_q;
  logic signed [DeviationW-1:0]  o_dev_q;

  // Per-sample helpers
  logic        [SW-1:0] ax;
  logic signed [SW:0]   diff_s;
  logic        [SW:0]   diff_abs;

  // Shared subtractor
  logic [CNT_W:0]   rem_shift;
  logic [ALU_W-1:0] alu_a, alu_b, alu_diff;
  logic             alu_ge;

  // Finish helpers
  logic        [DEV_W-1:0] dev_abs;
  logic signed [DEV_W:0]   prom_s;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPD;
      end
      ST_UPD:  state_d = ST_ACC;
      ST_ACC:  state_d = closing_q ? ST_DIV : ST_IDLE;
      ST_DIV: begin
        if (iter_q == '0) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (iter_q == '0) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    upd_en     = 1'b0;
    acc_en     = 1'b0;
    div_en     = 1'b0;
    sqrt_en    = 1'b0;
    fin_go     = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_UPD:  upd_en     = 1'b1;
      ST_ACC:  acc_en     = 1'b1;
      ST_DIV:  div_en     = 1'b1;
      ST_SQRT: sqrt_en    = 1'b1;
      // wait for the output register to free up
      ST_FIN:  fin_go     = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  assign ax       = abs_s(x_q);
  assign diff_s   = {x_q[SW-1], x_q} - {prev_q[SW-1], prev_q};
  assign diff_abs = diff_s[SW] ? (~diff_s + 1'b1) : diff_s;

  // One subtractor serves the divide (remainder minus length) and the root
  // (radicand minus trial value)
  assign rem_shift = {rem_q, dq_q[SQ_W-1]};
  assign alu_a     = div_en ? ALU_W'(rem_shift) : ALU_W'(xr_q);
  assign alu_b     = div_en ? ALU_W'(count_q) : ALU_W'(r_q | bit_q);
  assign alu_diff  = alu_a - alu_b;
  assign alu_ge    = !alu_diff[ALU_W-1];

  assign dev_abs = dev_q[DEV_W-1] ? (~dev_q + 1'b1) : dev_q;
  assign prom_s  = $signed({2'b00, best_abs_q, 1'b0}) - $signed({1'b0, dev_abs});

  always_comb begin
    count_d    = count_q;
    first_d    = first_q;
    prev_d     = prev_q;
    best_abs_d = best_abs_q;
    best_sgn_d = best_sgn_q;
    best_idx_d = best_idx_q;
    max_d      = max_q;
    min_d      = min_q;
    step_d     = step_q;
    abs_sum_d  = abs_sum_q;
    sq_sum_d   = sq_sum_q;
    closing_d  = closing_q;
    iter_d     = iter_q;
    sq_d       = sq_q;
    dev_d      = dev_q;
    edge_d     = edge_q;
    dq_d       = dq_q;
    rem_d      = rem_q;
    xr_d       = xr_q;
    r_d        = r_q;
    bit_d      = bit_q;

    if (upd_en) begin
      if (count_q == '0) begin
        first_d    = x_q;
        max_d      = x_q;
        min_d      = x_q;
        best_abs_d = ax;
        best_sgn_d = x_q;
        best_idx_d = '0;
      end else begin
        if (diff_abs[SW-1:0] > step_q) step_d = diff_abs[SW-1:0];
        if (x_q > max_q) max_d = x_q;
        if (x_q < min_q) min_d = x_q;
        // strict compare keeps the earliest peak on ties
        if (ax > best_abs_q) begin
          best_abs_d = ax;
          best_sgn_d = x_q;
          best_idx_d = IDX_W'(count_q);
        end
      end
      abs_sum_d = abs_sum_q + ASUM_W'(ax);
      sq_d      = (2 * SW)'(ax) * (2 * SW)'(ax);
      prev_d    = x_q;
      count_d   = count_q + 1'b1;
      closing_d = last_q || (count_q == CNT_W'(MAX_WINDOW - 1));
    end

    if (acc_en) begin
      sq_sum_d = sq_sum_q + SQ_W'(sq_q);
      if (closing_q) begin
        dq_d   = sq_sum_d;
        rem_d  = '0;
        iter_d = ITER_W'(SQ_W - 1);
        dev_d  = DEV_W'(first_q) + DEV_W'(x_q) - (DEV_W'(base_q) <<< 1);
        edge_d = (SW + 1)'(abs_s(first_q)) + (SW + 1)'(ax);
      end
    end

    if (div_en) begin
      dq_d   = {dq_q[SQ_W-2:0], alu_ge};
      rem_d  = alu_ge ? alu_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      iter_d = iter_q - 1'b1;
      if (iter_q == '0) begin
        // quotient is complete: seed the root
        xr_d   = {dq_q[Q_W-2:0], alu_ge};
        r_d    = '0;
        bit_d  = Q_W'(1) << (Q_W - 1);
        iter_d = ITER_W'(SW - 1);
      end
    end

    if (sqrt_en) begin
      if (alu_ge) begin
        xr_d = alu_diff[Q_W-1:0];
        r_d  = (r_q >> 1) | bit_q;
      end else begin
        r_d  = r_q >> 1;
      end
      bit_d  = bit_q >> 2;
      iter_d = iter_q - 1'b1;
    end

    if (fin_go) begin
      count_d    = '0;
      first_d    = '0;
      prev_d     = '0;
      best_abs_d = '0;
      best_sgn_d = '0;
      best_idx_d = '0;
      max_d      = '0;
      min_d      = '0;
      step_d     = '0;
      abs_sum_d  = '0;
      sq_sum_d   = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      closing_q   <= 1'b0;
      iter_q      <= '0;
      count_q     <= '0;
      first_q     <= '0;
      prev_q      <= '0;
      best_abs_q  <= '0;
      best_sgn_q  <= '0;
      best_idx_q  <= '0;
      max_q       <= '0;
      min_q       <= '0;
      step_q      <= '0;
      abs_sum_q   <= '0;
      sq_sum_q    <= '0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      closing_q   <= closing_d;
      iter_q      <= iter_d;
      count_q     <= count_d;
      first_q     <= first_d;
      prev_q      <= prev_d;
      best_abs_q  <= best_abs_d;
      best_sgn_q  <= best_sgn_d;
      best_idx_q  <= best_idx_d;
      max_q       <= max_d;
      min_q       <= min_d;
      step_q      <= step_d;
      abs_sum_q   <= abs_sum_d;
      sq_sum_q    <= sq_sum_d;
      if (cfg_we_i) base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q    <= sample_i;
      last_q <= last_sample_i;
    end
    sq_q   <= sq_d;
    dev_q  <= dev_d;
    edge_q <= edge_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    xr_q   <= xr_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    if (fin_go) begin
      o_peak_q   <= best_sgn_q;
      o_abs_q    <= best_abs_q;
      o_prom_q   <= prom_s[DEV_W] ? '0 : ProminenceW'(prom_s);
      o_max_q    <= max_q;
      o_min_q    <= min_q;
      o_idx_q    <= IndexW'(best_idx_q);
      o_len_q    <= LengthW'(count_q);
      o_step_q   <= step_q;
      o_area_q   <= AreaW'({abs_sum_q, 1'b0}) - AreaW'(edge_q);
      o_rms_q    <= SW'(r_q);
      o_energy_q <= EnergyW'(sq_sum_q);
      o_dev_q    <= DeviationW'(dev_q);
    end
  end

  assign out_valid_o                = out_valid_q;
  assign peak_amplitude_o           = o_peak_q;
  assign abs_peak_o                 = o_abs_q;
  assign twice_prominence_o         = o_prom_q;
  assign positive_excursion_o       = o_max_q;
  assign negative_excursion_o       = o_min_q;
  assign peak_index_o               = o_idx_q;
  assign window_length_o            = o_len_q;
  assign max_abs_step_o             = o_step_q;
  assign twice_area_o               = o_area_q;
  assign rms_value_o                = o_rms_q;
  assign energy_o                   = o_energy_q;
  assign twice_baseline_deviation_o = o_dev_q;

endmodule

@@ rtl/wpfe_checker.sv @@
// ----------------------------------------------------------------------------
// wpfe_checker
// Port-level checks for the window peak feature extractor, bound to the top.
// ----------------------------------------------------------------------------
module wpfe_checker
  import wpfe_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SampleW-1:0]     peak_amplitude_o,
  input logic        [SampleW-1:0]     abs_peak_o,
  input logic signed [SampleW-1:0]     positive_excursion_o,
  input logic signed [SampleW-1:0]     negative_excursion_o,
  input logic        [AreaW-1:0]       twice_area_o,
  input logic        [SampleW-1:0]     rms_value_o,
  input logic        [EnergyW-1:0]     energy_o
);

  // hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(energy_o)
      && $stable(peak_amplitude_o) && $stable(twice_area_o))
    else $error("result word changed while stalled");

  // busy for the update after each accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("word accepted during sample update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> positive_excursion_o >= negative_excursion_o
      && peak_amplitude_o <= positive_excursion_o
      && peak_amplitude_o >= negative_excursion_o)
    else $error("peak outside the window excursions");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rms_value_o <= abs_peak_o)
    else $error("rms above peak magnitude");

endmodule

bind window_peak_feature_extractor wpfe_checker u_wpfe_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for window_peak_feature_extractor. A short stimulus
// table covers field extremes, magnitude ties and baseline extremes. Random
// windows follow under changing handshake idling, including one full-length
// window closed without its marker. An in-bench window tracker predicts each
// result word, and every result is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import wpfe_pkg::*;

  localparam int SettleCycles = 64;
  localparam int CycleLimit   = 200000;

  typedef struct packed {
    logic signed [SampleW-1:0]    peak;
    logic        [SampleW-1:0]    abs_peak;
    logic        [ProminenceW-1:0] prom;
    logic signed [SampleW-1:0]    hi;
    logic signed [SampleW-1:0]    lo;
    logic        [IndexW-1:0]     idx;
    logic        [LengthW-1:0]    len;
    logic        [SampleW-1:0]    step;
    logic        [AreaW-1:0]      area;
    logic        [SampleW-1:0]    rms;
    logic        [EnergyW-1:0]    energy;
    logic signed [DeviationW-1:0] dev;
  } features_t;

  typedef enum logic {ROW_WORD, ROW_BASE} row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    logic signed [SampleW-1:0] value;
    logic                      is_last;
    bit                        fixed;
    features_t                 want;
  } row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [SampleW-1:0]     sample_i = '0;
  logic                          last_sample_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [SampleW-1:0]     peak_amplitude_o;
  logic        [SampleW-1:0]     abs_peak_o;
  logic        [ProminenceW-1:0] twice_prominence_o;
  logic signed [SampleW-1:0]     positive_excursion_o;
  logic signed [SampleW-1:0]     negative_excursion_o;
  logic        [IndexW-1:0]      peak_index_o;
  logic        [LengthW-1:0]     window_length_o;
  logic        [SampleW-1:0]     max_abs_step_o;
  logic        [AreaW-1:0]       twice_area_o;
  logic        [SampleW-1:0]     rms_value_o;
  logic        [EnergyW-1:0]     energy_o;
  logic signed [DeviationW-1:0]  twice_baseline_deviation_o;
  logic                          cfg_we_i = 1'b0;
  logic signed [SampleW-1:0]     cfg_wdata_i = '0;

  window_peak_feature_extractor u_dut (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .in_valid_i                 (in_valid_i),
    .in_ready_o                 (in_ready_o),
    .sample_i                   (sample_i),
    .last_sample_i              (last_sample_i),
    .out_valid_o                (out_valid_o),
    .out_ready_i                (out_ready_i),
    .peak_amplitude_o           (peak_amplitude_o),
    .abs_peak_o                 (abs_peak_o),
    .twice_prominence_o         (twice_prominence_o),
    .positive_excursion_o       (positive_excursion_o),
    .negative_excursion_o       (negative_excursion_o),
    .peak_index_o               (peak_index_o),
    .window_length_o            (window_length_o),
    .max_abs_step_o             (max_abs_step_o),
    .twice_area_o               (twice_area_o),
    .rms_value_o                (rms_value_o),
    .energy_o                   (energy_o),
    .twice_baseline_deviation_o (twice_baseline_deviation_o),
    .cfg_we_i                   (cfg_we_i),
    .cfg_wdata_i                (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 0;
  end

  // Window tracker state, kept at the block's widths; the peak magnitude has one more bit
  logic        [LengthW-1:0]  acc_count = '0;
  logic signed [SampleW-1:0]  acc_first = '0;
  logic signed [SampleW-1:0]  acc_prev = '0;
  logic        [SampleW:0]    acc_peak_mag = '0;
  logic signed [SampleW-1:0]  acc_peak_val = '0;
  logic        [IndexW-1:0]   acc_peak_idx = '0;
  logic signed [SampleW-1:0]  acc_hi = '0;
  logic signed [SampleW-1:0]  acc_lo = '0;
  logic        [SampleW-1:0]  acc_step = '0;
  logic        [23:0]         acc_mag_sum = '0;
  logic        [EnergyW-1:0]  acc_sq_sum = '0;
  logic signed [SampleW-1:0]  base_level = '0;

  features_t feature_q[$];
  features_t seen_result;
  row_t      dir_rows[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int i = 20; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // Fold one word into the window; return 1 and the features when it closes
  function automatic bit track_word(input logic signed [SampleW-1:0] s,
                                    input logic is_last, output features_t f);
    longint x, mag, stp, dev, prom, area, first_mag;
    longint unsigned mean;
    x = longint'(s);
    mag = (x < 0) ? -x : x;
    f = '0;
    if (acc_count == '0) begin
      acc_first    = s;
      acc_hi       = s;
      acc_lo       = s;
      acc_peak_mag = mag[SampleW:0];
      acc_peak_val = s;
      acc_peak_idx = '0;
    end else begin
      stp = x - longint'(acc_prev);
      if (stp < 0) stp = -stp;
      if (stp > longint'(acc_step)) acc_step = stp[SampleW-1:0];
      if (s > acc_hi) acc_hi = s;
      if (s < acc_lo) acc_lo = s;
      // strict compare: the earliest of equal magnitudes stays the peak
      if (mag > longint'(acc_peak_mag)) begin
        acc_peak_mag = mag[SampleW:0];
        acc_peak_val = s;
        acc_peak_idx = acc_count[IndexW-1:0];
      end
    end
    acc_mag_sum = acc_mag_sum + mag[23:0];
    acc_sq_sum  = acc_sq_sum + EnergyW'(mag * mag);
    acc_prev    = s;
    acc_count   = acc_count + 1'b1;
    if (!is_last && acc_count < MaxWindowDef) return 1'b0;

    dev = longint'(acc_first) + x - 2 * longint'(base_level);
    prom = 2 * longint'(acc_peak_mag) - ((dev < 0) ? -dev : dev);
    if (prom < 0) prom = 0;
    first_mag = (acc_first < 0) ? -longint'(acc_first) : longint'(acc_first);
    area = 2 * longint'(acc_mag_sum) - first_mag - mag;
    mean = longint'(acc_sq_sum) / longint'(acc_count);
    f = features_t'{acc_peak_val, acc_peak_mag[SampleW-1:0], prom[ProminenceW-1:0],
                    acc_hi, acc_lo, acc_peak_idx, acc_count, acc_step,
                    area[AreaW-1:0], SampleW'(floor_sqrt(mean)), acc_sq_sum,
                    dev[DeviationW-1:0]};
    acc_count    = '0;
    acc_first    = '0;
    acc_prev     = '0;
    acc_peak_mag = '0;
    acc_peak_val = '0;
    acc_peak_idx = '0;
    acc_hi       = '0;
    acc_lo       = '0;
    acc_step     = '0;
    acc_mag_sum  = '0;
    acc_sq_sum   = '0;
    return 1'b1;
  endfunction

  function automatic string show(input features_t v);
    return {$sformatf("peak=%0d abs=%0d prom=%0d max=%0d min=%0d idx=%0d ",
                      v.peak, v.abs_peak, v.prom, v.hi, v.lo, v.idx),
            $sformatf("len=%0d step=%0d area=%0d rms=%0d energy=%0d dev=%0d",
                      v.len, v.step, v.area, v.rms, v.energy, v.dev)};
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample(
      input logic signed [SampleW-1:0] prev);
    int v;
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return -prev;  // same magnitude, opposite sign
      4: return prev;
      5, 6: begin
        v = int'($urandom_range(400)) - 200;
        return v[SampleW-1:0];
      end
      default: return SampleW'($urandom);
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic signed [SampleW-1:0] s, input logic is_last,
                           input bit fixed, input features_t fixed_want);
    features_t f;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    last_sample_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    if (track_word(s, is_last, f)) feature_q.push_back(fixed ? fixed_want : f);
    @(negedge clk_i);
  endtask

  // Drain all pending results, let the block settle, then write the baseline
  task automatic set_baseline(input logic signed [SampleW-1:0] level);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (feature_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= level;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    base_level = level;
  endtask

  task automatic random_windows(input int budget);
    int sent;
    int len;
    logic signed [SampleW-1:0] s;
    sent = 0;
    s = '0;
    while (sent < budget) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
        s = pick_sample(s);
        send_word(s, k == len - 1, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result = features_t'{peak_amplitude_o, abs_peak_o, twice_prominence_o,
                                positive_excursion_o, negative_excursion_o,
                                peak_index_o, window_length_o, max_abs_step_o,
                                twice_area_o, rms_value_o, energy_o,
                                twice_baseline_deviation_o};
      if (feature_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result: %s", show(seen_result));
      end else if (seen_result !== feature_q[0]) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result mismatch");
          $display("  expected: %s", show(feature_q[0]));
          $display("  actual:   %s", show(seen_result));
        end
        void'(feature_q.pop_front());
      end else begin
        void'(feature_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // Fixed rows: expected words typed in where the numbers are obvious
    // Field order: peak abs prom max min idx len step area rms energy dev
    dir_rows.push_back(row_t'{ROW_WORD, 16'sh7fff, 1'b1, 1'b1, features_t'{
        32767, 32767, 0, 32767, 32767, 0, 1, 0, 0, 32767, 1073676289, 65534}});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sh8000, 1'b1, 1'b1, features_t'{
        -32768, 32768, 0, -32768, -32768, 0, 1, 0, 0, 32768, 1073741824, -65536}});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sh0000, 1'b1, 1'b1, features_t'{
        0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0}});
    // full-scale swing: later larger magnitude takes the peak
    dir_rows.push_back(row_t'{ROW_WORD, 16'sh7fff, 1'b0, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sh8000, 1'b1, 1'b0, '0});
    // magnitude ties keep the earliest sample
    dir_rows.push_back(row_t'{ROW_WORD, -16'sd7, 1'b0, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sd7, 1'b0, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sd3, 1'b0, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, -16'sd7, 1'b1, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sh5555, 1'b0, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, 16'shaaaa, 1'b1, 1'b0, '0});
    // baseline extremes drive the deviation to both ends
    dir_rows.push_back(row_t'{ROW_BASE, 16'sh7fff, 1'b0, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sh8000, 1'b1, 1'b1, features_t'{
        -32768, 32768, 0, -32768, -32768, 0, 1, 0, 0, 32768, 1073741824, -131070}});
    dir_rows.push_back(row_t'{ROW_BASE, 16'sh8000, 1'b0, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sh7fff, 1'b1, 1'b1, features_t'{
        32767, 32767, 0, 32767, 32767, 0, 1, 0, 0, 32767, 1073676289, 131070}});
    dir_rows.push_back(row_t'{ROW_BASE, 16'sd1000, 1'b0, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sd1000, 1'b0, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sd5, 1'b0, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sd1000, 1'b1, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, -16'sd1, 1'b0, 1'b0, '0});
    dir_rows.push_back(row_t'{ROW_WORD, 16'sd1, 1'b1, 1'b0, '0});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_BASE) begin
        set_baseline(dir_rows[i].value);
      end else begin
        send_word(dir_rows[i].value, dir_rows[i].is_last, dir_rows[i].fixed,
                  dir_rows[i].want);
      end
    end

    send_idle_pct = 11;
    recv_idle_pct = 83;
    set_baseline(SampleW'($urandom));
    random_windows(65);

    send_idle_pct = 83;
    recv_idle_pct = 11;
    set_baseline(SampleW'(int'($urandom_range(2000)) - 1000));
    random_windows(65);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_baseline('0);
    // full-length window with no marker; the peak lands on the final word
    for (int k = 0; k < MaxWindowDef; k++) begin
      send_word((k == MaxWindowDef - 1) ? 16'sh8000 :
                ($urandom_range(1) ? 16'sh7fff : -16'sh7fff), 1'b0, 1'b0, '0);
    end
    random_windows(35);

    in_valid_i <= 1'b0;
    while (feature_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
